FILE: rtl/mmh3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash3 string hash package
// Constants, datapath operation codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package mmh3_pkg;

  // Reset value of the seed register.
  localparam logic [31:0] SEED_RESET = 32'hc467_5a42;

  // Block mix constants.
  localparam logic [31:0] MIX_C1  = 32'hcc9e_2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b87_3593;
  localparam logic [31:0] MIX_ADD = 32'he654_6b64;
  localparam int unsigned MIX_ROT1 = 15;
  localparam int unsigned MIX_ROT2 = 13;

  // Final avalanche constants.
  localparam logic [31:0] AVL_C1 = 32'h85eb_ca6b;
  localparam logic [31:0] AVL_C2 = 32'hc2b2_ae35;
  localparam int unsigned AVL_SH1 = 16;
  localparam int unsigned AVL_SH2 = 13;

  // Operations the controller issues to the datapath, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,   // absorb the accepted input transaction
    OP_MIX1,   // w = w * C1
    OP_MIX2,   // w = rotl(w, 15) * C2
    OP_MIX3,   // h = rotl(h ^ w, 13) * 5 + ADD
    OP_TAIL,   // w = leftover bytes, phase cleared
    OP_AVL1,   // w = ((h ^ len) ^ >>16) * AC1
    OP_AVL2,   // w = (w ^ >>13) * AC2
    OP_DONE    // result = w ^ >>16, clear string state
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic phase_full;   // three bytes held, the next byte completes a word
    logic phase_nz;     // leftover bytes are held
  } dp_status_t;

  // Left rotate of a 32-bit word by a constant amount.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

endpackage

FILE: rtl/mmh3_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed configuration channel
// Valid/ready write channel carrying the seed register value.
// ----------------------------------------------------------------------------
interface mmh3_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/mmh3_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one string byte or an end marker.
// ----------------------------------------------------------------------------
interface mmh3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input last,
                  output ready);
endinterface

FILE: rtl/mmh3_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash result channel
// Valid/ready channel carrying one 32-bit string hash.
// ----------------------------------------------------------------------------
interface mmh3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

FILE: rtl/mmh3_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash3 datapath
// Hash state, byte assembly and one shared 32x32 multiplier driven by the
// controller's operation code.
// ----------------------------------------------------------------------------
module mmh3_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mmh3_pkg::dp_cmd_t     cmd_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  byte_valid_i,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_data_i,
  output mmh3_pkg::dp_status_t  status_o,
  output logic [31:0]           hash_value_o
);
  import mmh3_pkg::*;

  logic [31:0] seed_q,    seed_d;
  logic [31:0] hash_q,    hash_d;
  logic [31:0] work_q,    work_d;
  logic [23:0] partial_q, partial_d;
  logic [1:0]  phase_q,   phase_d;
  logic [31:0] count_q,   count_d;
  logic        started_q, started_d;
  logic [31:0] result_q,  result_d;

  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] len_mix, avl_mix, mix_rot;

  // Shared multiplier operand selection.
  always_comb begin
    len_mix = (hash_q ^ count_q) ^ ((hash_q ^ count_q) >> AVL_SH1);
    avl_mix = work_q ^ (work_q >> AVL_SH2);
    mul_a   = work_q;
    mul_b   = MIX_C1;
    case (cmd_i.op)
      OP_MIX2: begin
        mul_a = rotl32(work_q, MIX_ROT1);
        mul_b = MIX_C2;
      end
      OP_AVL1: begin
        mul_a = len_mix;
        mul_b = AVL_C1;
      end
      OP_AVL2: begin
        mul_a = avl_mix;
        mul_b = AVL_C2;
      end
      default: begin
        mul_a = work_q;
        mul_b = MIX_C1;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Second half of the block mix: rotate, times five, add.
  assign mix_rot = rotl32(hash_q ^ work_q, MIX_ROT2);

  // Next-state logic for the hash state.
  always_comb begin
    seed_d    = seed_q;
    hash_d    = hash_q;
    work_d    = work_q;
    partial_d = partial_q;
    phase_d   = phase_q;
    count_d   = count_q;
    started_d = started_q;
    result_d  = result_q;

    case (cmd_i.op)
      OP_TAKE: begin
        if (byte_valid_i) begin
          started_d = 1'b1;
          count_d   = count_q + 32'd1;
          case (phase_q)
            2'd0: begin
              partial_d[7:0] = data_byte_i;
              phase_d        = 2'd1;
            end
            2'd1: begin
              partial_d[15:8] = data_byte_i;
              phase_d         = 2'd2;
            end
            2'd2: begin
              partial_d[23:16] = data_byte_i;
              phase_d          = 2'd3;
            end
            default: begin
              work_d    = {data_byte_i, partial_q};
              partial_d = '0;
              phase_d   = 2'd0;
            end
          endcase
        end
      end
      OP_MIX1, OP_MIX2, OP_AVL1, OP_AVL2: begin
        work_d = mul_p;
      end
      OP_MIX3: begin
        hash_d = (mix_rot << 2) + mix_rot + MIX_ADD;
      end
      OP_TAIL: begin
        work_d    = {8'd0, partial_q};
        partial_d = '0;
        phase_d   = 2'd0;
      end
      OP_DONE: begin
        result_d  = work_q ^ (work_q >> AVL_SH1);
        hash_d    = seed_q;
        partial_d = '0;
        phase_d   = 2'd0;
        count_d   = '0;
        started_d = 1'b0;
      end
      default: begin
      end
    endcase

    // A seed write also reloads the hash when no string is in progress.
    if (cfg_we_i) begin
      seed_d = cfg_data_i;
      if (!started_d) begin
        hash_d = cfg_data_i;
      end
    end
  end

  // Control and hash state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= SEED_RESET;
      hash_q    <= SEED_RESET;
      partial_q <= '0;
      phase_q   <= 2'd0;
      count_q   <= '0;
      started_q <= 1'b0;
    end else begin
      seed_q    <= seed_d;
      hash_q    <= hash_d;
      partial_q <= partial_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
      started_q <= started_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    result_q <= result_d;
  end

  assign status_o.phase_full = (phase_q == 2'd3);
  assign status_o.phase_nz   = (phase_q != 2'd0);
  assign hash_value_o        = result_q;

endmodule

FILE: rtl/mmh3_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash3 controller
// Sequences block mixes, the leftover-byte mix and the final avalanche, and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module mmh3_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_byte_valid_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  mmh3_pkg::dp_status_t  status_i,
  output mmh3_pkg::dp_cmd_t     cmd_o
);
  import mmh3_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MIX1 = 8'b0000_0010,
    S_MIX2 = 8'b0000_0100,
    S_MIX3 = 8'b0000_1000,
    S_TAIL = 8'b0001_0000,
    S_AVL1 = 8'b0010_0000,
    S_AVL2 = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  logic   out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Next-state and command decode.
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = OP_NONE;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_o.op = OP_TAKE;
          last_d   = in_last_i;
          if (in_byte_valid_i && status_i.phase_full) begin
            state_d = S_MIX1;
          end else if (in_last_i) begin
            state_d = S_TAIL;
          end
        end
      end
      S_MIX1: begin
        cmd_o.op = OP_MIX1;
        state_d  = S_MIX2;
      end
      S_MIX2: begin
        cmd_o.op = OP_MIX2;
        state_d  = S_MIX3;
      end
      S_MIX3: begin
        cmd_o.op = OP_MIX3;
        state_d  = last_q ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        // Leftover bytes go through one more block mix; the phase clears,
        // so the second visit moves on to the avalanche.
        if (status_i.phase_nz) begin
          cmd_o.op = OP_TAIL;
          state_d  = S_MIX1;
        end else begin
          state_d = S_AVL1;
        end
      end
      S_AVL1: begin
        cmd_o.op = OP_AVL1;
        state_d  = S_AVL2;
      end
      S_AVL2: begin
        cmd_o.op = OP_AVL2;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.op    = OP_DONE;
          out_valid_d = 1'b1;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/murmur3_string_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash3 string hash core
// Hashes a byte string, one byte per transaction, into a 32-bit value.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                          Meaning
//  cfg_i     in         data[31:0]                       seed register write
//  in_i      in         data_byte, byte_valid, last      string byte / end mark
//  out_o     out        hash_value[31:0]                 hash of one string
//
//  A byte that does not complete a word is absorbed directly; a byte that completes
//  a word also runs 3 block-mix steps on the single shared multiplier.
//  An item with last adds a tail check, two avalanche multiplies and a
//  result load, plus a tail load and a block mix for 1 to 3 leftover bytes.
//  The result waits in an output register; the next string's bytes are taken
//  while it waits, and only the next result load stalls on out_o.ready.
//  Reset loads the seed and hash with the default and clears the control state.
//  The configuration channel is always ready.
//
module murmur3_string_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmh3_cfg_if.sink    cfg_i,
  mmh3_in_if.sink     in_i,
  mmh3_out_if.source  out_o
);
  import mmh3_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       cfg_we;

  // Seed writes are taken in any cycle.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  mmh3_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_byte_valid_i (in_i.byte_valid),
    .in_last_i       (in_i.last),
    .in_ready_o      (in_i.ready),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .status_i        (dp_status),
    .cmd_o           (dp_cmd)
  );

  mmh3_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .data_byte_i  (in_i.data_byte),
    .byte_valid_i (in_i.byte_valid),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_i.data),
    .status_o     (dp_status),
    .hash_value_o (out_o.hash_value)
  );

endmodule
